@@ rtl/tcic_pkg.sv @@
// Shared types and constants for the text command integer calculator.
// Holds operation codes, character codes and default sizes; no dependencies.
package tcic_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MUL_DIGIT_DEF   = 8;
  localparam int RESULT_WIDTH    = 32;
  localparam int CHAR_WIDTH      = 8;

  // Character codes
  localparam logic [CHAR_WIDTH-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_WIDTH-1:0] CH_NUL     = 8'd0;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'd48;

  // Operator text, first byte in the low bits
  localparam logic [23:0] OPT_PLUS    = 24'h00002B;
  localparam logic [23:0] OPT_MINUS   = 24'h00002D;
  localparam logic [23:0] OPT_STAR    = 24'h00002A;
  localparam logic [23:0] OPT_SLASH   = 24'h00002F;
  localparam logic [23:0] OPT_PERCENT = 24'h000025;
  localparam logic [23:0] OPT_POWER   = 24'h002A2A;
  localparam logic [23:0] OPT_ESC_UP  = 24'h435345;
  localparam logic [23:0] OPT_ESC_LO  = 24'h637365;

  // Operation codes carried from the parser to the execution unit
  typedef logic [2:0] op_t;
  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_MOD = 3'd4;
  localparam op_t OP_POW = 3'd5;
  localparam op_t OP_NOP = 3'd6;  // unknown operator: re-emit accumulator
  localparam op_t OP_CLR = 3'd7;  // escape line: clear accumulator, no output

  typedef struct packed {
    op_t  op;
    logic use_acc;  // first operand is the accumulator
  } cmd_ctrl_t;

endpackage

@@ rtl/tcic_front.sv @@
// Line parser: takes one character per transaction and builds a command per line.
// Depends on tcic_pkg; feeds tcic_queue.
module tcic_front #(
  parameter int W = tcic_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcic_pkg::CHAR_WIDTH-1:0]     in_character,
  input  logic                                q_full,
  output logic                                push,
  output tcic_pkg::cmd_ctrl_t                 push_ctrl,
  output logic [W-1:0]                        push_a,
  output logic [W-1:0]                        push_b
);

  localparam logic [1:0] FP_OP   = 2'd0;
  localparam logic [1:0] FP_NUM1 = 2'd1;
  localparam logic [1:0] FP_NUM2 = 2'd2;
  localparam logic [1:0] FP_SKIP = 2'd3;

  logic [23:0]  op_text_r, op_text_nxt;
  logic [1:0]   op_len_r, op_len_nxt;
  logic [1:0]   fpos_r, fpos_nxt;
  logic [W-1:0] first_r, first_nxt;
  logic [W-1:0] second_r, second_nxt;
  logic         second_seen_r, second_seen_nxt;

  logic         accept;
  logic         newline;
  logic         is_esc;
  logic [W-1:0] first_dig;
  logic [W-1:0] second_dig;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign newline  = (in_character == tcic_pkg::CH_NEWLINE);

  // value * 10 + char - 48, wrapping at W bits
  assign first_dig  = {first_r[W-4:0], 3'b000} + {first_r[W-2:0], 1'b0}
                    + W'(in_character) - W'(tcic_pkg::CH_ZERO);
  assign second_dig = {second_r[W-4:0], 3'b000} + {second_r[W-2:0], 1'b0}
                    + W'(in_character) - W'(tcic_pkg::CH_ZERO);

  assign is_esc = (fpos_r == FP_OP) && (op_len_r == 2'd3) &&
                  ((op_text_r == tcic_pkg::OPT_ESC_UP) || (op_text_r == tcic_pkg::OPT_ESC_LO));

  // Classify the operator of the finished line
  always_comb begin
    push_ctrl.use_acc = ~second_seen_r;
    priority if (is_esc) begin
      push_ctrl.op = tcic_pkg::OP_CLR;
    end else if (op_len_r == 2'd1 && op_text_r == tcic_pkg::OPT_PLUS) begin
      push_ctrl.op = tcic_pkg::OP_ADD;
    end else if (op_len_r == 2'd1 && op_text_r == tcic_pkg::OPT_MINUS) begin
      push_ctrl.op = tcic_pkg::OP_SUB;
    end else if (op_len_r == 2'd1 && op_text_r == tcic_pkg::OPT_STAR) begin
      push_ctrl.op = tcic_pkg::OP_MUL;
    end else if (op_len_r == 2'd1 && op_text_r == tcic_pkg::OPT_SLASH) begin
      push_ctrl.op = tcic_pkg::OP_DIV;
    end else if (op_len_r == 2'd1 && op_text_r == tcic_pkg::OPT_PERCENT) begin
      push_ctrl.op = tcic_pkg::OP_MOD;
    end else if (op_len_r == 2'd2 && op_text_r == tcic_pkg::OPT_POWER) begin
      push_ctrl.op = tcic_pkg::OP_POW;
    end else begin
      push_ctrl.op = tcic_pkg::OP_NOP;
    end
  end

  // Pick operands: two-number form or accumulator form
  assign push_a = first_r;
  assign push_b = second_seen_r ? second_r : ((fpos_r == FP_OP) ? '0 : first_r);

  // Advance the line state per character
  always_comb begin
    op_text_nxt     = op_text_r;
    op_len_nxt      = op_len_r;
    fpos_nxt        = fpos_r;
    first_nxt       = first_r;
    second_nxt      = second_r;
    second_seen_nxt = second_seen_r;
    push            = 1'b0;
    if (accept) begin
      if (newline) begin
        push            = 1'b1;
        op_text_nxt     = '0;
        op_len_nxt      = '0;
        fpos_nxt        = FP_OP;
        first_nxt       = '0;
        second_nxt      = '0;
        second_seen_nxt = 1'b0;
      end else begin
        unique case (fpos_r)
          FP_OP: begin
            if (in_character == tcic_pkg::CH_SPACE) begin
              fpos_nxt = FP_NUM1;
            end else begin
              unique case (op_len_r)
                2'd0: begin
                  op_text_nxt[7:0] = in_character;
                  op_len_nxt       = 2'd1;
                end
                2'd1: begin
                  op_text_nxt[15:8] = in_character;
                  op_len_nxt        = 2'd2;
                end
                2'd2: begin
                  op_text_nxt[23:16] = in_character;
                  op_len_nxt         = 2'd3;
                end
                2'd3: begin
                  // operator too long: make it unknown
                  op_text_nxt = '0;
                end
              endcase
            end
          end
          FP_NUM1: begin
            if (in_character == tcic_pkg::CH_SPACE) begin
              fpos_nxt        = FP_NUM2;
              second_seen_nxt = 1'b1;
            end else if (in_character == tcic_pkg::CH_NUL) begin
              fpos_nxt = FP_SKIP;
            end else begin
              first_nxt = first_dig;
            end
          end
          FP_NUM2: begin
            if (in_character == tcic_pkg::CH_SPACE || in_character == tcic_pkg::CH_NUL) begin
              fpos_nxt = FP_SKIP;
            end else begin
              second_nxt = second_dig;
            end
          end
          FP_SKIP: begin
            fpos_nxt = FP_SKIP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_text_r     <= '0;
      op_len_r      <= '0;
      fpos_r        <= FP_OP;
      first_r       <= '0;
      second_r      <= '0;
      second_seen_r <= 1'b0;
    end else begin
      op_text_r     <= op_text_nxt;
      op_len_r      <= op_len_nxt;
      fpos_r        <= fpos_nxt;
      first_r       <= first_nxt;
      second_r      <= second_nxt;
      second_seen_r <= second_seen_nxt;
    end
  end

endmodule

@@ rtl/tcic_queue.sv @@
// Small command FIFO between the parser and the execution unit.
// No package dependencies; payload width and depth come from parameters.
module tcic_queue #(
  parameter int PW    = 40,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [PW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output logic [PW-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [PW-1:0] entries [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = entries[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/tcic_mul.sv @@
// Iterative multiplier: one DIGIT-bit slice of the multiplier per cycle, low W bits kept.
// No package dependencies; used by tcic_back for multiply and power.
module tcic_mul #(
  parameter int W     = 32,
  parameter int DIGIT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] mul_a,
  input  logic [W-1:0] mul_b,
  output logic         done,
  output logic [W-1:0] product
);

  logic [W-1:0] mcand_r, mcand_nxt;
  logic [W-1:0] mplier_r, mplier_nxt;
  logic [W-1:0] prod_r, prod_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [W-1:0] partial;

  assign partial = W'(mcand_r * mplier_r[DIGIT-1:0]);
  assign done    = done_r;
  assign product = prod_r;

  // Accumulate one partial product per cycle, stop once the multiplier runs out
  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (busy_r) begin
      prod_nxt   = prod_r + partial;
      mcand_nxt  = mcand_r << DIGIT;
      mplier_nxt = mplier_r >> DIGIT;
      if ((mplier_r >> DIGIT) == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      mcand_nxt  = mul_a;
      mplier_nxt = mul_b;
      prod_nxt   = '0;
      busy_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
  end

endmodule

@@ rtl/tcic_back.sv @@
// Execution unit: pops commands, runs add/sub, multiply, power, divide and modulo,
// keeps the accumulator and drives the result register. Depends on tcic_pkg, tcic_mul.
module tcic_back #(
  parameter int W     = tcic_pkg::DATA_WIDTH_DEF,
  parameter int DIGIT = tcic_pkg::MUL_DIGIT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  tcic_pkg::cmd_ctrl_t                  q_ctrl,
  input  logic [W-1:0]                         q_a,
  input  logic [W-1:0]                         q_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tcic_pkg::RESULT_WIDTH-1:0] out_result,
  output logic                                 out_divide_by_zero
);

  localparam int RW = tcic_pkg::RESULT_WIDTH;
  localparam int CW = $clog2(W + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_POW_CHK  = 3'd2;
  localparam logic [2:0] S_POW_WAIT = 3'd3;
  localparam logic [2:0] S_DIV      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          dz_r, dz_nxt;
  logic [W-1:0]  pacc_r, pacc_nxt;
  logic [W-1:0]  psq_r, psq_nxt;
  logic [W-1:0]  pexp_r, pexp_nxt;
  logic          phase_r, phase_nxt;
  logic [W-1:0]  dq_r, dq_nxt;
  logic [W-1:0]  drem_r, drem_nxt;
  logic [W-1:0]  dden_r, dden_nxt;
  logic [CW-1:0] dcnt_r, dcnt_nxt;
  logic          neg_a_r, neg_a_nxt;
  logic          neg_b_r, neg_b_nxt;
  logic          is_mod_r, is_mod_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [RW-1:0] out_res_r, out_res_nxt;
  logic          out_dz_r, out_dz_nxt;

  logic [W-1:0]  opa;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          mul_start;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic          mul_done;
  logic [W-1:0]  mul_prod;
  logic [RW-1:0] res_ext;

  tcic_mul #(
    .W     (W),
    .DIGIT (DIGIT)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign opa   = q_ctrl.use_acc ? acc_r : q_a;
  assign mag_a = opa[W-1] ? (W'(0) - opa) : opa;
  assign mag_b = q_b[W-1] ? (W'(0) - q_b) : q_b;

  // One restoring division step
  assign trial = {drem_r, dq_r[W-1]};
  assign diff  = trial - {1'b0, dden_r};

  // Fit the W-bit result to the 32-bit result port
  generate
    if (W >= RW) begin : g_trunc
      assign res_ext = res_r[RW-1:0];
    end else begin : g_sext
      assign res_ext = {{(RW - W){res_r[W-1]}}, res_r};
    end
  endgenerate

  assign out_valid          = out_valid_r;
  assign out_result         = out_res_r;
  assign out_divide_by_zero = out_dz_r;

  // Command sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    dz_nxt        = dz_r;
    pacc_nxt      = pacc_r;
    psq_nxt       = psq_r;
    pexp_nxt      = pexp_r;
    phase_nxt     = phase_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    dden_nxt      = dden_r;
    dcnt_nxt      = dcnt_r;
    neg_a_nxt     = neg_a_r;
    neg_b_nxt     = neg_b_r;
    is_mod_nxt    = is_mod_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_res_nxt   = out_res_r;
    out_dz_nxt    = out_dz_r;
    q_pop         = 1'b0;
    mul_start     = 1'b0;
    mul_a         = pacc_r;
    mul_b         = psq_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          dz_nxt = 1'b0;
          unique case (q_ctrl.op)
            tcic_pkg::OP_ADD: begin
              res_nxt   = opa + q_b;
              state_nxt = S_DONE;
            end
            tcic_pkg::OP_SUB: begin
              res_nxt   = opa - q_b;
              state_nxt = S_DONE;
            end
            tcic_pkg::OP_NOP: begin
              res_nxt   = acc_r;
              state_nxt = S_DONE;
            end
            tcic_pkg::OP_CLR: begin
              acc_nxt = '0;
            end
            tcic_pkg::OP_MUL: begin
              mul_start = 1'b1;
              mul_a     = opa;
              mul_b     = q_b;
              state_nxt = S_MUL;
            end
            tcic_pkg::OP_POW: begin
              if (q_b == '0 || q_b[W-1]) begin
                res_nxt   = W'(1);
                state_nxt = S_DONE;
              end else begin
                pacc_nxt  = W'(1);
                psq_nxt   = opa;
                pexp_nxt  = q_b;
                state_nxt = S_POW_CHK;
              end
            end
            tcic_pkg::OP_DIV, tcic_pkg::OP_MOD: begin
              if (q_b == '0) begin
                res_nxt   = '0;
                dz_nxt    = 1'b1;
                state_nxt = S_DONE;
              end else begin
                neg_a_nxt  = opa[W-1];
                neg_b_nxt  = q_b[W-1];
                is_mod_nxt = (q_ctrl.op == tcic_pkg::OP_MOD);
                dq_nxt     = mag_a;
                dden_nxt   = mag_b;
                drem_nxt   = '0;
                dcnt_nxt   = CW'(W);
                state_nxt  = S_DIV;
              end
            end
          endcase
        end
      end

      S_MUL: begin
        if (mul_done) begin
          res_nxt   = mul_prod;
          state_nxt = S_DONE;
        end
      end

      // Square-and-multiply, one exponent bit per pass
      S_POW_CHK: begin
        if (pexp_r == '0) begin
          res_nxt   = pacc_r;
          state_nxt = S_DONE;
        end else if (pexp_r[0]) begin
          mul_start = 1'b1;
          mul_a     = pacc_r;
          mul_b     = psq_r;
          phase_nxt = 1'b0;
          state_nxt = S_POW_WAIT;
        end else begin
          mul_start = 1'b1;
          mul_a     = psq_r;
          mul_b     = psq_r;
          phase_nxt = 1'b1;
          state_nxt = S_POW_WAIT;
        end
      end

      S_POW_WAIT: begin
        if (mul_done) begin
          if (!phase_r) begin
            pacc_nxt = mul_prod;
            if (pexp_r[W-1:1] == '0) begin
              // last exponent bit: no further squaring needed
              res_nxt   = mul_prod;
              state_nxt = S_DONE;
            end else begin
              mul_start = 1'b1;
              mul_a     = psq_r;
              mul_b     = psq_r;
              phase_nxt = 1'b1;
            end
          end else begin
            psq_nxt   = mul_prod;
            pexp_nxt  = pexp_r >> 1;
            state_nxt = S_POW_CHK;
          end
        end
      end

      // Restoring division on magnitudes, then fix signs
      S_DIV: begin
        if (dcnt_r != '0) begin
          dcnt_nxt = dcnt_r - 1'b1;
          if (!diff[W]) begin
            drem_nxt = diff[W-1:0];
          end else begin
            drem_nxt = trial[W-1:0];
          end
          dq_nxt = {dq_r[W-2:0], ~diff[W]};
        end else begin
          if (is_mod_r) begin
            res_nxt = neg_a_r ? (W'(0) - drem_r) : drem_r;
          end else begin
            res_nxt = (neg_a_r != neg_b_r) ? (W'(0) - dq_r) : dq_r;
          end
          state_nxt = S_DONE;
        end
      end

      // Commit accumulator and hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          acc_nxt       = res_r;
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_ext;
          out_dz_nxt    = dz_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    dz_r      <= dz_nxt;
    pacc_r    <= pacc_nxt;
    psq_r     <= psq_nxt;
    pexp_r    <= pexp_nxt;
    phase_r   <= phase_nxt;
    dq_r      <= dq_nxt;
    drem_r    <= drem_nxt;
    dden_r    <= dden_nxt;
    dcnt_r    <= dcnt_nxt;
    neg_a_r   <= neg_a_nxt;
    neg_b_r   <= neg_b_nxt;
    is_mod_r  <= is_mod_nxt;
    out_res_r <= out_res_nxt;
    out_dz_r  <= out_dz_nxt;
  end

endmodule

@@ rtl/text_command_integer_calculator.sv @@
// Text command calculator: one character per transaction on the in_ channel; each
// newline yields at most one transaction on the out_ channel. The parser takes a
// character every cycle while the command queue (QUEUE_DEPTH lines) has room and
// hands finished lines to that queue, so typing continues while a line executes. The
// back-end sequencer computes add, subtract and unknown operators in its idle state,
// multiplies in the 8-bit-per-cycle multiplier, divides and takes the modulo in the
// 1-bit-per-cycle restoring divider, and runs power as up to two multiplies per
// exponent bit, about 2*log2(exponent) multiplies. An ESC or esc line clears the
// accumulator and produces no result. Depends on tcic_pkg and the tcic_front,
// tcic_queue, tcic_mul and tcic_back modules.
module text_command_integer_calculator #(
  parameter int DATA_WIDTH  = tcic_pkg::DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = tcic_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [tcic_pkg::CHAR_WIDTH-1:0]          in_character,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [tcic_pkg::RESULT_WIDTH-1:0] out_result,
  output logic                                     out_divide_by_zero
);

  localparam int CTW = $bits(tcic_pkg::cmd_ctrl_t);
  localparam int PW  = CTW + 2 * DATA_WIDTH;

  logic                      q_full;
  logic                      push;
  tcic_pkg::cmd_ctrl_t       push_ctrl;
  logic [DATA_WIDTH-1:0]     push_a;
  logic [DATA_WIDTH-1:0]     push_b;
  logic                      q_pop;
  logic                      q_valid;
  logic [PW-1:0]             q_data;
  tcic_pkg::cmd_ctrl_t       q_ctrl;
  logic [DATA_WIDTH-1:0]     q_a;
  logic [DATA_WIDTH-1:0]     q_b;

  tcic_front #(
    .W (DATA_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .q_full       (q_full),
    .push         (push),
    .push_ctrl    (push_ctrl),
    .push_a       (push_a),
    .push_b       (push_b)
  );

  tcic_queue #(
    .PW    (PW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctrl, push_a, push_b}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // Unpack the queued command
  assign q_ctrl = tcic_pkg::cmd_ctrl_t'(q_data[PW-1 -: CTW]);
  assign q_a    = q_data[2*DATA_WIDTH-1 -: DATA_WIDTH];
  assign q_b    = q_data[DATA_WIDTH-1:0];

  tcic_back #(
    .W     (DATA_WIDTH),
    .DIGIT (tcic_pkg::MUL_DIGIT_DEF)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_ctrl             (q_ctrl),
    .q_a                (q_a),
    .q_b                (q_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result         (out_result),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

@@ tb/sv/text_command_integer_calculator_tb.sv @@
// Self-checking testbench for the text command calculator: feeds command text one
// character at a time and checks every emitted result against a built-in predictor.
// Depends on tcic_pkg and the text_command_integer_calculator RTL only.
`timescale 1ns / 100ps

module text_command_integer_calculator_tb;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int TAIL_CYCLES   = 1000;
  localparam int LONG_HOLD     = 600;
  localparam int REPORT_LIMIT  = 10;

  // Parser position within a line
  typedef enum logic [1:0] {
    FLD_OPERATOR,
    FLD_FIRST,
    FLD_SECOND,
    FLD_SKIP
  } field_t;

  typedef struct {
    logic [31:0] value;
    logic        div_zero;
  } result_t;

  logic                    clk;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  logic [tcic_pkg::CHAR_WIDTH-1:0] in_character = '0;
  logic                    out_valid;
  logic                    out_stall    = 1'b0;
  logic signed [tcic_pkg::RESULT_WIDTH-1:0] out_result;
  logic                    out_divide_by_zero;

  // Stimulus and scoreboard storage
  logic [7:0]  char_queue[$];
  result_t     pending_results[$];
  int          chars_queued    = 0;
  int          mismatch_count  = 0;
  int          cycle_count     = 0;
  int          send_idle_pct   = 0;
  int          recv_idle_pct   = 0;
  logic        hold_kick       = 1'b0;
  int          hold_left       = 0;
  result_t     head;

  // Calculator state as the predictor sees it
  logic [23:0] opr_text;
  logic [1:0]  opr_len;
  field_t      field_pos;
  logic [31:0] first_num;
  logic [31:0] second_num;
  logic        second_present;
  logic [31:0] accum;

  string known_ops[6] = '{"+", "-", "*", "/", "%", "**"};
  string odd_ops[6]   = '{"x", "+-", "***", "**-", "abcde", ""};
  string esc_words[6] = '{"ESC", "esc", "Esc", "ESCX", "esc 1", "ES"};

  text_command_integer_calculator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_character       (in_character),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result         (out_result),
    .out_divide_by_zero (out_divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Signed divide on magnitudes; truncate toward zero, remainder follows the dividend
  function automatic logic [31:0] wrap_divide(logic [31:0] a, logic [31:0] b,
                                              bit want_rem);
    logic [31:0] ma, mb, q, r;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    r  = ma % mb;
    if (want_rem)
      return a[31] ? -r : r;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Square-and-multiply, wrapping at 32 bits; non-positive exponent gives 1
  function automatic logic [31:0] wrap_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] prod, sq;
    int          k;
    if (ex == 32'd0 || ex[31])
      return 32'd1;
    prod = 32'd1;
    sq   = base;
    for (k = 0; k < 32; k++) begin
      if (ex[k])
        prod = prod * sq;
      sq = sq * sq;
    end
    return prod;
  endfunction

  function automatic logic [31:0] add_digit(logic [31:0] v, logic [7:0] c);
    return v * 32'd10 + {24'b0, c} - {24'b0, tcic_pkg::CH_ZERO};
  endfunction

  function automatic void clear_line();
    opr_text       = '0;
    opr_len        = '0;
    field_pos      = FLD_OPERATOR;
    first_num      = '0;
    second_num     = '0;
    second_present = 1'b0;
  endfunction

  // Advance the calculator by one character; queue the result a newline produces
  function automatic void calc_on_char(logic [7:0] c);
    logic [31:0] lhs, rhs, value;
    logic        dz;
    result_t     r;
    if (c == tcic_pkg::CH_NEWLINE) begin
      if (field_pos == FLD_OPERATOR && opr_len == 2'd3 &&
          (opr_text == tcic_pkg::OPT_ESC_UP || opr_text == tcic_pkg::OPT_ESC_LO)) begin
        accum = '0;
      end else begin
        if (second_present) begin
          lhs = first_num;
          rhs = second_num;
        end else begin
          lhs = accum;
          rhs = (field_pos == FLD_OPERATOR) ? 32'd0 : first_num;
        end
        value = accum;
        dz    = 1'b0;
        if (opr_len == 2'd1 && opr_text == tcic_pkg::OPT_PLUS)
          value = lhs + rhs;
        else if (opr_len == 2'd1 && opr_text == tcic_pkg::OPT_MINUS)
          value = lhs - rhs;
        else if (opr_len == 2'd1 && opr_text == tcic_pkg::OPT_STAR)
          value = lhs * rhs;
        else if (opr_len == 2'd1 && (opr_text == tcic_pkg::OPT_SLASH ||
                                     opr_text == tcic_pkg::OPT_PERCENT)) begin
          if (rhs == 32'd0) begin
            value = '0;
            dz    = 1'b1;
          end else begin
            value = wrap_divide(lhs, rhs, opr_text == tcic_pkg::OPT_PERCENT);
          end
        end else if (opr_len == 2'd2 && opr_text == tcic_pkg::OPT_POWER)
          value = wrap_power(lhs, rhs);
        accum      = value;
        r.value    = value;
        r.div_zero = dz;
        pending_results.push_back(r);
      end
      clear_line();
    end else begin
      case (field_pos)
        FLD_OPERATOR: begin
          if (c == tcic_pkg::CH_SPACE) begin
            field_pos = FLD_FIRST;
          end else if (opr_len < 2'd3) begin
            opr_text[8*opr_len +: 8] = c;
            opr_len = opr_len + 2'd1;
          end else begin
            opr_text = '0;
          end
        end
        FLD_FIRST: begin
          if (c == tcic_pkg::CH_SPACE) begin
            field_pos      = FLD_SECOND;
            second_present = 1'b1;
          end else if (c == tcic_pkg::CH_NUL) begin
            field_pos = FLD_SKIP;
          end else begin
            first_num = add_digit(first_num, c);
          end
        end
        FLD_SECOND: begin
          if (c == tcic_pkg::CH_SPACE || c == tcic_pkg::CH_NUL)
            field_pos = FLD_SKIP;
          else
            second_num = add_digit(second_num, c);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void push_byte(logic [7:0] c);
    char_queue.push_back(c);
    chars_queued++;
  endfunction

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++)
      push_byte(s[i]);
  endfunction

  // Operand text: mostly small or mid-size values, some full-range, some garbage
  function automatic string number_text();
    case ($urandom_range(9))
      0:       return "";
      1, 2, 3: return $sformatf("%0d", $urandom_range(12));
      4, 5:    return $sformatf("%0d", $urandom_range(99999));
      6, 7:    return $sformatf("%0d", $urandom());
      8:       return $sformatf("%0d", 32'h7FFF_FFFF + $urandom_range(2));
      default: return $sformatf("%c%0d", $urandom_range(33, 126), $urandom_range(99));
    endcase
  endfunction

  // Queue one line: mostly well-formed commands, some noise and broken lines
  function automatic void queue_random_line();
    string opr;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
    end else if (pick < 15) begin
      push_text(esc_words[$urandom_range(5)]);
    end else begin
      opr = ($urandom_range(9) == 0) ? odd_ops[$urandom_range(5)]
                                     : known_ops[$urandom_range(5)];
      push_text(opr);
      push_text(" ");
      push_text(number_text());
      if ($urandom_range(9) < 7) begin
        push_text(" ");
        push_text(number_text());
      end
      case ($urandom_range(19))
        0: begin
          push_byte(tcic_pkg::CH_NUL);
          push_text($sformatf("%0d", $urandom_range(999)));
        end
        1: push_text($sformatf(" %0d", $urandom_range(999)));
        default: ;
      endcase
    end
    push_byte(tcic_pkg::CH_NEWLINE);
  endfunction

  function automatic void queue_directed_lines();
    push_text("+ 2147483647 1\n");
    push_text("- 0 1\n");
    push_text("* 65536 65536\n");
    push_text("/ 7 0\n");
    push_text("% 7 0\n");
    push_text("/ 2147483648 4294967295\n");
    push_text("% 2147483648 4294967295\n");
    push_text("/ 4294967289 2\n");
    push_text("% 4294967289 2\n");
    push_text("** 3 0\n");
    push_text("** 2 4294967295\n");
    push_text("** 3 40\n");
    push_text("+ 5\n");
    push_text("ESC\n");
    push_text("+ 9\n");
    push_text("esc\n");
    push_text("+\n");
    push_text("\n");
    push_text("abcd 1 2\n");
    push_text("? 1 2\n");
    // zero byte ends the first number, then the rest is skipped
    push_text("* 12");
    push_byte(tcic_pkg::CH_NUL);
    push_text(" 9\n");
    push_text("- 9 4 77\n");
    push_text("+ 3 4");
    push_byte(tcic_pkg::CH_NUL);
    push_text("9\n");
    // high-bit bytes inside a number
    push_text("+ ");
    push_byte(8'hFF);
    push_byte(8'h80);
    push_text(" 1\n");
    push_text("**\n");
  endfunction

  function automatic void log_failure(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s", $realtime, what);
  endfunction

  // Drive characters; predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        calc_on_char(in_character);
      if (!in_valid || !in_stall) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_character <= char_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold once kicked
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_kick)
      hold_left <= LONG_HOLD;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          log_failure($sformatf("result %0d with none expected", out_result));
        end else begin
          head = pending_results.pop_front();
          if (out_result !== head.value || out_divide_by_zero !== head.div_zero)
            log_failure($sformatf("result expected %0d/%0b got %0d/%0b",
                                  $signed(head.value), head.div_zero,
                                  out_result, out_divide_by_zero));
        end
      end
      out_stall <= hold_kick || (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk)
    cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Wait until every queued character went out and every result came back
  task automatic drain();
    while (char_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Phases: receiver-heavy idling, sender-heavy idling, then full rate with a long hold
  initial begin
    clear_line();
    accum = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 61;
    queue_directed_lines();
    while (chars_queued < 450)
      queue_random_line();
    drain();

    send_idle_pct = 61;
    recv_idle_pct = 24;
    while (chars_queued < 900)
      queue_random_line();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (chars_queued < 1350)
      queue_random_line();
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tcic_pkg.sv
rtl/tcic_front.sv
rtl/tcic_queue.sv
rtl/tcic_mul.sv
rtl/tcic_back.sv
rtl/text_command_integer_calculator.sv
tb/sv/text_command_integer_calculator_tb.sv
